// ----- hw/rtl/yuv_interleaved_to_planar_writer_top_macros.svh -----
// assertion macros for the interleaved-to-planar writer
// used by the checker; expects clk and rst_n in scope
`ifndef YUV_INTERLEAVED_TO_PLANAR_WRITER_TOP_MACROS_SVH
`define YUV_INTERLEAVED_TO_PLANAR_WRITER_TOP_MACROS_SVH

// consequent must hold in the same cycle
`define YIPW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define YIPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/yipw_pkg.sv -----
// shared constants for the interleaved-to-planar yuv420 writer
// no dependencies
package yipw_pkg;

    localparam int MAX_DIM_DEF = 1024;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int ADDR_W      = 21;
    localparam int WORD_W      = 16;
    localparam int PLANE_W     = 2;
    localparam int OFFSET_W    = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] VIEW_WIDTH_RST   = 11'd640;
    localparam logic [CFG_DATA_W-1:0] VIEW_HEIGHT_RST  = 11'd480;
    localparam logic [OFFSET_W-1:0]   OFFSET_X_RST     = 10'd0;
    localparam logic [OFFSET_W-1:0]   OFFSET_Y_RST     = 10'd0;
    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

    // plane codes
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    // word phase within a four-pixel group
    localparam logic [1:0] PHASE_LUMA0  = 2'd0;
    localparam logic [1:0] PHASE_LUMA1  = 2'd1;
    localparam logic [1:0] PHASE_CHROMA = 2'd2;

    // cycles of input stall after reset or a register write
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

endpackage

// ----- hw/rtl/yuv_interleaved_to_planar_writer_top.sv -----
// top level of the interleaved-to-planar yuv420 writer
// depends on yipw_pkg
//
//   channel  signals                                         direction
//   in       in_valid, in_ready, source_word                 upstream -> block
//   out      out_valid, out_ready, write_address, write_data,
//            plane, last_of_frame                            block -> downstream
//   cfg      cfg_write, cfg_index, cfg_data                  host -> block
//
// one item per cycle while in_ready is high; its write is registered on acceptance
// the per-item path is the pointer add and the column/line compares into that register
// after reset or any register write in_ready stays low while two
// registered multipliers rebuild the plane start addresses and line steps
// with the output register full, in_ready follows out_ready
module yuv_interleaved_to_planar_writer_top #(
    parameter int MAX_DIM = yipw_pkg::MAX_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [yipw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [yipw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [yipw_pkg::WORD_W-1:0]       source_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [yipw_pkg::ADDR_W-1:0]       write_address,
    output logic [yipw_pkg::WORD_W-1:0]       write_data,
    output logic [yipw_pkg::PLANE_W-1:0]      plane,
    output logic                              last_of_frame
);

    localparam int CFG_W  = yipw_pkg::CFG_DATA_W;
    localparam int OFS_W  = yipw_pkg::OFFSET_W;
    localparam int ADDR_W = yipw_pkg::ADDR_W;
    localparam int WORD_W = yipw_pkg::WORD_W;
    localparam int AREA_W = 2 * CFG_W;
    localparam int LINE_W = $clog2(MAX_DIM + 1);
    localparam int GRP_W  = $clog2(MAX_DIM / 4 + 1);
    localparam int CMP_W  = (LINE_W > CFG_W) ? LINE_W : CFG_W;
    localparam int MAX_W  = (MAX_DIM / 4) * 4;

    // configuration registers
    logic [CFG_W-1:0] view_width_reg, view_height_reg, image_width_reg, image_height_reg;
    logic [OFS_W-1:0] offset_x_reg, offset_y_reg;
    logic [1:0]       settle_reg, settle_next;

    // derived geometry, first stage
    logic [AREA_W-1:0] area_reg;
    logic [ADDR_W-1:0] pitch_off_reg;
    logic [CMP_W-1:0]  eff_w_reg, eff_w_next, w_mask;
    logic [LINE_W-1:0] eff_h_reg, eff_h_next;
    logic [CMP_W-1:0]  h_ext;

    // derived geometry, second stage
    logic [ADDR_W-1:0] y_start_reg, u_start_reg, v_start_reg;
    logic [ADDR_W-1:0] ystep_reg, cstep2_reg;
    logic [GRP_W-1:0]  groups_reg;
    logic [ADDR_W-1:0] coff;
    logic signed [CMP_W:0] diff, diff_adj, ystep_s, cstep_s;

    // walk state
    logic [1:0]        word_phase_reg, word_phase_next;
    logic [GRP_W-1:0]  column_count_reg, column_count_next, column_inc;
    logic [LINE_W-1:0] line_count_reg, line_count_next, line_inc;
    logic [ADDR_W-1:0] luma_pointer_reg, luma_pointer_next;
    logic [ADDR_W-1:0] blue_pointer_reg, blue_pointer_next;
    logic [ADDR_W-1:0] red_pointer_reg, red_pointer_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]             write_address_reg, addr_sel;
    logic [WORD_W-1:0]             write_data_reg;
    logic [yipw_pkg::PLANE_W-1:0]  plane_reg, plane_sel;
    logic                          last_reg;

    logic accept, is_chroma, odd_line, end_of_line, end_of_frame, reload;
    logic [ADDR_W-1:0] chroma_ptr, chroma_ptr_adv;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_width_reg   <= yipw_pkg::VIEW_WIDTH_RST;
            view_height_reg  <= yipw_pkg::VIEW_HEIGHT_RST;
            offset_x_reg     <= yipw_pkg::OFFSET_X_RST;
            offset_y_reg     <= yipw_pkg::OFFSET_Y_RST;
            image_width_reg  <= yipw_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= yipw_pkg::IMAGE_HEIGHT_RST;
            settle_reg       <= yipw_pkg::SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    yipw_pkg::REG_VIEW_WIDTH:   view_width_reg   <= cfg_data;
                    yipw_pkg::REG_VIEW_HEIGHT:  view_height_reg  <= cfg_data;
                    yipw_pkg::REG_OFFSET_X:     offset_x_reg     <= cfg_data[OFS_W-1:0];
                    yipw_pkg::REG_OFFSET_Y:     offset_y_reg     <= cfg_data[OFS_W-1:0];
                    yipw_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    yipw_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        settle_next = (settle_reg != 2'd0) ? settle_reg - 2'd1 : settle_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                yipw_pkg::REG_VIEW_WIDTH,
                yipw_pkg::REG_VIEW_HEIGHT,
                yipw_pkg::REG_OFFSET_X,
                yipw_pkg::REG_OFFSET_Y,
                yipw_pkg::REG_IMAGE_WIDTH,
                yipw_pkg::REG_IMAGE_HEIGHT: settle_next = yipw_pkg::SETTLE_CYCLES;
                default: ;
            endcase
        end
    end

    // ---------------- geometry, stage one ----------------
    always_comb
    begin
        // width rounded down to four pixels, clamped to [4, MAX_W]
        w_mask = CMP_W'({image_width_reg[CFG_W-1:2], 2'b00});
        if (w_mask < CMP_W'(4))
            eff_w_next = CMP_W'(4);
        else if (w_mask > CMP_W'(MAX_W))
            eff_w_next = CMP_W'(MAX_W);
        else
            eff_w_next = w_mask;

        h_ext = CMP_W'(image_height_reg);
        if (h_ext == '0)
            eff_h_next = LINE_W'(1);
        else if (h_ext > CMP_W'(MAX_DIM))
            eff_h_next = LINE_W'(MAX_DIM);
        else
            eff_h_next = LINE_W'(h_ext);
    end

    always_ff @(posedge clk)
    begin
        area_reg      <= AREA_W'(view_width_reg) * AREA_W'(view_height_reg);
        pitch_off_reg <= ADDR_W'(view_width_reg) * ADDR_W'(offset_y_reg);
        eff_w_reg     <= eff_w_next;
        eff_h_reg     <= eff_h_next;
    end

    // ---------------- geometry, stage two ----------------
    always_comb
    begin
        coff = (pitch_off_reg >> 2) + ADDR_W'(offset_x_reg >> 1);
        diff = $signed({1'b0, CMP_W'(view_width_reg)}) - $signed({1'b0, eff_w_reg});
        // halve toward zero
        diff_adj = diff + $signed({{CMP_W{1'b0}}, diff[CMP_W]});
        ystep_s  = (diff_adj >>> 1) <<< 1;
        cstep_s  = (diff_adj >>> 2) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        y_start_reg <= pitch_off_reg + ADDR_W'(offset_x_reg);
        u_start_reg <= ADDR_W'(area_reg) + coff;
        v_start_reg <= ADDR_W'(area_reg) + ADDR_W'(area_reg >> 2) + coff;
        groups_reg  <= GRP_W'(eff_w_reg >> 2);
        ystep_reg   <= ADDR_W'(ystep_s);
        cstep2_reg  <= ADDR_W'(cstep_s) + ADDR_W'(2);
    end

    // ---------------- per-item walk ----------------
    assign in_ready = (settle_reg == 2'd0) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign reload   = (settle_reg == 2'd1);

    always_comb
    begin
        is_chroma    = (word_phase_reg == yipw_pkg::PHASE_CHROMA);
        odd_line     = line_count_reg[0];
        column_inc   = column_count_reg + GRP_W'(1);
        line_inc     = line_count_reg + LINE_W'(1);
        end_of_line  = is_chroma && (column_inc >= groups_reg);
        end_of_frame = end_of_line && (line_inc >= eff_h_reg);

        chroma_ptr     = odd_line ? red_pointer_reg : blue_pointer_reg;
        chroma_ptr_adv = chroma_ptr + (end_of_line ? cstep2_reg : ADDR_W'(2));

        if (is_chroma)
        begin
            addr_sel  = chroma_ptr;
            plane_sel = odd_line ? yipw_pkg::PLANE_V : yipw_pkg::PLANE_U;
        end
        else
        begin
            addr_sel  = luma_pointer_reg;
            plane_sel = yipw_pkg::PLANE_Y;
        end

        word_phase_next   = word_phase_reg;
        column_count_next = column_count_reg;
        line_count_next   = line_count_reg;
        luma_pointer_next = luma_pointer_reg;
        blue_pointer_next = blue_pointer_reg;
        red_pointer_next  = red_pointer_reg;

        if (reload || (accept && end_of_frame))
        begin
            word_phase_next   = yipw_pkg::PHASE_LUMA0;
            column_count_next = '0;
            line_count_next   = '0;
            luma_pointer_next = y_start_reg;
            blue_pointer_next = u_start_reg;
            red_pointer_next  = v_start_reg;
        end
        else if (accept)
        begin
            if (!is_chroma)
            begin
                word_phase_next   = word_phase_reg + 2'd1;
                luma_pointer_next = luma_pointer_reg + ADDR_W'(2);
            end
            else
            begin
                word_phase_next = yipw_pkg::PHASE_LUMA0;
                if (odd_line)
                    red_pointer_next = chroma_ptr_adv;
                else
                    blue_pointer_next = chroma_ptr_adv;
                if (end_of_line)
                begin
                    column_count_next = '0;
                    line_count_next   = line_inc;
                    luma_pointer_next = luma_pointer_reg + ystep_reg;
                end
                else
                begin
                    column_count_next = column_inc;
                end
            end
        end

        out_valid_next = accept || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_phase_reg   <= yipw_pkg::PHASE_LUMA0;
            column_count_reg <= '0;
            line_count_reg   <= '0;
            luma_pointer_reg <= '0;
            blue_pointer_reg <= '0;
            red_pointer_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            word_phase_reg   <= word_phase_next;
            column_count_reg <= column_count_next;
            line_count_reg   <= line_count_next;
            luma_pointer_reg <= luma_pointer_next;
            blue_pointer_reg <= blue_pointer_next;
            red_pointer_reg  <= red_pointer_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            write_address_reg <= addr_sel;
            write_data_reg    <= source_word;
            plane_reg         <= plane_sel;
            last_reg          <= end_of_frame;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;
    assign plane         = plane_reg;
    assign last_of_frame = last_reg;

endmodule

// ----- hw/rtl/yipw_checker.sv -----
// port-level checks for the interleaved-to-planar writer, bound to the top level
// depends on yipw_pkg and yuv_interleaved_to_planar_writer_top_macros.svh
`include "yuv_interleaved_to_planar_writer_top_macros.svh"

module yipw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_write,
    input logic [yipw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [yipw_pkg::ADDR_W-1:0]       write_address,
    input logic [yipw_pkg::WORD_W-1:0]       write_data,
    input logic [yipw_pkg::PLANE_W-1:0]      plane,
    input logic                              last_of_frame
);

    // a stalled write holds its payload
    `YIPW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(write_address) && $stable(write_data) && $stable(plane)
        && $stable(last_of_frame), "stalled write changed")

    // frame ends only on a chroma word
    `YIPW_ASSERT_NOW(a_last_chroma, out_valid && last_of_frame,
        plane != yipw_pkg::PLANE_Y, "last of frame on a luma word")

    // a register write blocks input while start addresses rebuild
    `YIPW_ASSERT_NEXT(a_cfg_stall, cfg_write && cfg_index <= yipw_pkg::REG_IMAGE_HEIGHT,
        !in_ready, "input taken right after a register write")

    // with a full output register, new items only come when it drains
    `YIPW_ASSERT_NOW(a_ready_drain, in_ready && out_valid, out_ready,
        "input ready while output is stalled")

endmodule

bind yuv_interleaved_to_planar_writer_top yipw_checker u_checker (.*);

// ----- tb/yuv_interleaved_to_planar_writer_top_test.sv -----
// self-checking testbench for yuv_interleaved_to_planar_writer_top
// depends on yipw_pkg and the writer rtl; keeps its own copy of the address
// sequencing and compares every planar write against it
module yuv_interleaved_to_planar_writer_top_test;

    typedef logic [yipw_pkg::ADDR_W-1:0]     addr_t;
    typedef logic [yipw_pkg::WORD_W-1:0]     word_t;
    typedef logic [yipw_pkg::CFG_IDX_W-1:0]  idx_t;
    typedef logic [yipw_pkg::CFG_DATA_W-1:0] cfg_t;

    typedef struct packed {
        addr_t                        addr;
        word_t                        data;
        logic [yipw_pkg::PLANE_W-1:0] plane;
        logic                         last;
    } planar_write_t;

    localparam int CYCLE_LIMIT = 500000;
    localparam int NUM_REGS    = 6;
    localparam int RANDOM_WORDS = 100;
    // indexes past the register list, the block must ignore them
    localparam idx_t REG_UNUSED_LO = 3'd6;
    localparam idx_t REG_UNUSED_HI = 3'd7;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    idx_t                         cfg_index = '0;
    cfg_t                         cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    word_t                        source_word = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    addr_t                        write_address;
    word_t                        write_data;
    logic [yipw_pkg::PLANE_W-1:0] plane;
    logic                         last_of_frame;

    yuv_interleaved_to_planar_writer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .source_word   (source_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_address (write_address),
        .write_data    (write_data),
        .plane         (plane),
        .last_of_frame (last_of_frame)
    );

    always #2 clk = ~clk;

    // register copy and frame position
    logic [10:0]   view_w, view_h, img_w, img_h;
    logic [9:0]    off_x, off_y;
    int unsigned   line_no, group_no;
    logic [1:0]    phase;
    addr_t         y_ptr, u_ptr, v_ptr;

    planar_write_t pending_writes[$];
    planar_write_t due_w;
    int            errors = 0;
    int            cycle_count = 0;
    bit            idle_on = 1'b1;
    int            stall_left = 0;
    int            hold_left = 0;

    function automatic int unsigned line_pixels();
        int unsigned w;
        w = 32'(img_w) & ~32'd3;
        if (w < 4) w = 4;
        if (w > (yipw_pkg::MAX_DIM_DEF & ~3)) w = yipw_pkg::MAX_DIM_DEF & ~3;
        return w;
    endfunction

    function automatic int unsigned frame_lines();
        int unsigned h;
        h = 32'(img_h);
        if (h == 0) h = 1;
        if (h > yipw_pkg::MAX_DIM_DEF) h = yipw_pkg::MAX_DIM_DEF;
        return h;
    endfunction

    function automatic void rewind_frame();
        int unsigned plane_size, chroma_off;
        plane_size = 32'(view_w) * 32'(view_h);
        chroma_off = (32'(view_w) * 32'(off_y)) / 4 + 32'(off_x) / 2;
        line_no  = 0;
        group_no = 0;
        phase    = yipw_pkg::PHASE_LUMA0;
        y_ptr    = addr_t'(32'(view_w) * 32'(off_y) + 32'(off_x));
        u_ptr    = addr_t'(plane_size + chroma_off);
        v_ptr    = addr_t'(plane_size + plane_size / 4 + chroma_off);
    endfunction

    function automatic void reset_registers();
        view_w = yipw_pkg::VIEW_WIDTH_RST;
        view_h = yipw_pkg::VIEW_HEIGHT_RST;
        off_x  = yipw_pkg::OFFSET_X_RST;
        off_y  = yipw_pkg::OFFSET_Y_RST;
        img_w  = yipw_pkg::IMAGE_WIDTH_RST;
        img_h  = yipw_pkg::IMAGE_HEIGHT_RST;
        rewind_frame();
    endfunction

    function automatic void set_register(input idx_t idx, input cfg_t val);
        case (idx)
            yipw_pkg::REG_VIEW_WIDTH:   view_w = val;
            yipw_pkg::REG_VIEW_HEIGHT:  view_h = val;
            yipw_pkg::REG_OFFSET_X:     off_x  = val[yipw_pkg::OFFSET_W-1:0];
            yipw_pkg::REG_OFFSET_Y:     off_y  = val[yipw_pkg::OFFSET_W-1:0];
            yipw_pkg::REG_IMAGE_WIDTH:  img_w  = val;
            yipw_pkg::REG_IMAGE_HEIGHT: img_h  = val;
            default:                    return;
        endcase
        // any valid write aborts the frame in progress
        rewind_frame();
    endfunction

    // address, plane and frame end for the next camera word
    function automatic planar_write_t plan_write(input word_t w);
        planar_write_t r;
        int            diff, s, half;
        bit            odd;
        odd    = (line_no % 2) != 0;
        r.data = w;
        r.last = 1'b0;
        if (phase == yipw_pkg::PHASE_LUMA0 || phase == yipw_pkg::PHASE_LUMA1)
        begin
            r.addr  = y_ptr;
            r.plane = yipw_pkg::PLANE_Y;
            y_ptr   = y_ptr + addr_t'(2);
            phase   = phase + 2'd1;
        end
        else
        begin
            if (odd)
            begin
                r.addr  = v_ptr;
                r.plane = yipw_pkg::PLANE_V;
                v_ptr   = v_ptr + addr_t'(2);
            end
            else
            begin
                r.addr  = u_ptr;
                r.plane = yipw_pkg::PLANE_U;
                u_ptr   = u_ptr + addr_t'(2);
            end
            phase    = yipw_pkg::PHASE_LUMA0;
            group_no = group_no + 1;
            if (group_no >= line_pixels() / 4)
            begin
                diff = int'(view_w) - int'(line_pixels());
                s    = diff / 2;
                // chroma step rounds toward minus infinity
                half = (s >= 0) ? s / 2 : -((1 - s) / 2);
                group_no = 0;
                y_ptr = y_ptr + addr_t'(2 * s);
                if (odd)
                    v_ptr = v_ptr + addr_t'(2 * half);
                else
                    u_ptr = u_ptr + addr_t'(2 * half);
                line_no = line_no + 1;
                if (line_no >= frame_lines())
                begin
                    r.last = 1'b1;
                    rewind_frame();
                end
            end
        end
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t unexpected write expected none actual addr %h data %h",
                         $time, write_address, write_data);
                errors++;
            end
            else
            begin
                due_w = pending_writes.pop_front();
                if (write_address !== due_w.addr)
                    report_field("write_address", 32'(due_w.addr), 32'(write_address));
                if (write_data !== due_w.data)
                    report_field("write_data", 32'(due_w.data), 32'(write_data));
                if (plane !== due_w.plane)
                    report_field("plane", 32'(due_w.plane), 32'(plane));
                if (last_of_frame !== due_w.last)
                    report_field("last_of_frame", 32'(due_w.last), 32'(last_of_frame));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL yuv_interleaved_to_planar_writer_top");
            $finish;
        end
    end

    // downstream: random stall bursts, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_word(input word_t w);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        source_word <= w;
        do @(posedge clk); while (!in_ready);
        pending_writes.push_back(plan_write(w));
    endtask

    task automatic send_random_words(input int n);
        repeat (n) send_word(word_t'($urandom()));
    endtask

    task automatic wait_writes_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input idx_t idx, input cfg_t val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        set_register(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic cfg_t pick_size(input int unsigned small_hi);
        case ($urandom_range(0, 7))
            0:       return 11'h7FF;
            1:       return 11'h000;
            2, 3:    return 11'($urandom_range(0, 2047));
            default: return 11'($urandom_range(0, small_hi));
        endcase
    endfunction

    function automatic cfg_t random_reg_value(input idx_t idx);
        case (idx)
            yipw_pkg::REG_VIEW_WIDTH,
            yipw_pkg::REG_VIEW_HEIGHT:  return pick_size(64);
            yipw_pkg::REG_IMAGE_WIDTH:  return pick_size(32);
            yipw_pkg::REG_IMAGE_HEIGHT: return pick_size(5);
            default:
                case ($urandom_range(0, 3))
                    0:       return 11'h000;
                    1:       return 11'h3FF;
                    default: return 11'($urandom_range(0, 2047));
                endcase
        endcase
    endfunction

    task automatic apply_random_config();
        bit any_written;
        int i;
        any_written = 1'b0;
        wait_writes_done();
        for (i = 0; i < NUM_REGS; i++)
        begin
            if ($urandom_range(0, 1) == 1 || (i == NUM_REGS - 1 && !any_written))
            begin
                write_reg(idx_t'(i), random_reg_value(idx_t'(i)));
                any_written = 1'b1;
            end
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED_HI, 11'($urandom_range(0, 2047)));
    endtask

    // pointers straight out of reset, word extremes
    task automatic test_reset_defaults();
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'hA5A5);
    endtask

    // width below four and zero height give a three-word frame
    task automatic test_zero_size();
        wait_writes_done();
        write_reg(yipw_pkg::REG_VIEW_WIDTH, 11'd4);
        write_reg(yipw_pkg::REG_VIEW_HEIGHT, 11'd2);
        write_reg(yipw_pkg::REG_IMAGE_WIDTH, 11'd0);
        write_reg(yipw_pkg::REG_IMAGE_HEIGHT, 11'd0);
        send_random_words(6);
    endtask

    // low width bits ignored, offsets applied, odd line goes to V
    task automatic test_partial_width();
        wait_writes_done();
        write_reg(yipw_pkg::REG_VIEW_WIDTH, 11'd8);
        write_reg(yipw_pkg::REG_OFFSET_X, 11'd3);
        write_reg(yipw_pkg::REG_OFFSET_Y, 11'd1);
        write_reg(yipw_pkg::REG_IMAGE_WIDTH, 11'd7);
        write_reg(yipw_pkg::REG_IMAGE_HEIGHT, 11'd2);
        send_random_words(6);
    endtask

    // negative line step with maximum offsets
    task automatic test_wider_than_view();
        wait_writes_done();
        write_reg(yipw_pkg::REG_VIEW_WIDTH, 11'd4);
        write_reg(yipw_pkg::REG_VIEW_HEIGHT, 11'h7FF);
        write_reg(yipw_pkg::REG_OFFSET_X, 11'h3FF);
        write_reg(yipw_pkg::REG_OFFSET_Y, 11'h7FF);
        write_reg(yipw_pkg::REG_IMAGE_WIDTH, 11'd8);
        send_random_words(12);
    endtask

    // writes past the register list must not restart the frame
    task automatic test_unused_index();
        send_random_words(2);
        wait_writes_done();
        write_reg(REG_UNUSED_LO, 11'h7FF);
        write_reg(REG_UNUSED_HI, 11'h000);
        send_random_words(2);
    endtask

    // output held off long enough to back up the input, then a full pause
    task automatic test_backpressure();
        wait_writes_done();
        write_reg(yipw_pkg::REG_VIEW_WIDTH, 11'd16);
        write_reg(yipw_pkg::REG_IMAGE_WIDTH, 11'd8);
        write_reg(yipw_pkg::REG_IMAGE_HEIGHT, 11'd3);
        write_reg(yipw_pkg::REG_OFFSET_X, 11'd0);
        write_reg(yipw_pkg::REG_OFFSET_Y, 11'd0);
        @(posedge clk);
        hold_left = 60;
        send_random_words(30);
        wait_writes_done();
        send_random_words(10);
    endtask

    task automatic test_random_frames();
        int sent;
        int n;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            apply_random_config();
            idle_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(1, 30);
            send_random_words(n);
            sent += n;
        end
        idle_on = 1'b1;
    endtask

    // group count saturates at the widest line
    task automatic test_oversize_width();
        wait_writes_done();
        write_reg(yipw_pkg::REG_VIEW_WIDTH, 11'd1024);
        write_reg(yipw_pkg::REG_VIEW_HEIGHT, 11'd2);
        write_reg(yipw_pkg::REG_OFFSET_X, 11'd0);
        write_reg(yipw_pkg::REG_OFFSET_Y, 11'd0);
        write_reg(yipw_pkg::REG_IMAGE_WIDTH, 11'h7FF);
        write_reg(yipw_pkg::REG_IMAGE_HEIGHT, 11'd1);
        send_random_words(3 * (yipw_pkg::MAX_DIM_DEF / 4) + 3);
    endtask

    // tall image with maximum offsets, narrow lines step through many rows
    task automatic test_oversize_height();
        wait_writes_done();
        write_reg(yipw_pkg::REG_VIEW_WIDTH, 11'h7FF);
        write_reg(yipw_pkg::REG_VIEW_HEIGHT, 11'h7FF);
        write_reg(yipw_pkg::REG_OFFSET_X, 11'h3FF);
        write_reg(yipw_pkg::REG_OFFSET_Y, 11'h3FF);
        write_reg(yipw_pkg::REG_IMAGE_WIDTH, 11'd4);
        write_reg(yipw_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
        send_random_words(24);
    endtask

    task automatic test_full_rate_tail();
        apply_random_config();
        idle_on = 1'b0;
        send_random_words(120);
    endtask

    initial
    begin
        reset_registers();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_size();
        test_partial_width();
        test_wider_than_view();
        test_unused_index();
        test_backpressure();
        test_random_frames();
        test_oversize_width();
        test_oversize_height();
        test_full_rate_tail();

        wait_writes_done();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASS yuv_interleaved_to_planar_writer_top");
        else
            $display("FAIL yuv_interleaved_to_planar_writer_top");
        $finish;
    end
endmodule
